// ===== rtl/core/adp_pkg.sv =====
// Shared types and constants for the Adam parameter update block.
// No dependencies; every other file of the block imports this package.
package adp_pkg;

   localparam int IDX_W      = 10;
   localparam int VAL_W      = 32;
   localparam int LR_W       = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int DIV_NUM_W = 88;
   localparam int DIV_DEN_W = 58;
   localparam int DIV_CNT_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA2   = 3'd4;

   localparam logic [23:0] RST_BASE_LR = 24'd16777;
   localparam logic [15:0] RST_EPSILON = 16'd429;
   localparam logic [15:0] RST_BETA1   = 16'd58982;
   localparam logic [15:0] RST_BETA2   = 16'd65470;

   typedef enum logic [4:0] {
      OP_NOP, OP_CLEAR, OP_CSR, OP_LOAD, OP_MOD, OP_READ,
      OP_M1, OP_M2, OP_M3, OP_G2, OP_V1, OP_V2, OP_V3, OP_V4,
      OP_DIV_M, OP_CAP_M, OP_DIV_V, OP_CAP_V, OP_SQRT, OP_CAP_S,
      OP_DIV_R, OP_CAP_R, OP_S1, OP_S2, OP_OUT, OP_E1, OP_E2,
      OP_RATE0, OP_RATE1, OP_CAP_LR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mod_last;
      logic div_done;
      logic sqrt_done;
      logic eos;
      logic decay_zero;
      logic csr_rate;
   } dp_status_type;

endpackage

// ===== rtl/core/adp_if.sv =====
// Valid/ready channel interfaces: request, response and register write.
// Depends on adp_pkg for field widths.
interface adp_req_if;
   import adp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        param_index;
   logic signed [VAL_W-1:0] param_value;
   logic signed [VAL_W-1:0] gradient;
   logic                    end_of_step;
   modport source (output valid, param_index, param_value, gradient, end_of_step,
                   input ready);
   modport sink   (input valid, param_index, param_value, gradient, end_of_step,
                   output ready);
endinterface

interface adp_rsp_if;
   import adp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] new_value;
   logic                    saturated;
   modport source (output valid, new_value, saturated, input ready);
   modport sink   (input valid, new_value, saturated, output ready);
endinterface

interface adp_csr_if;
   import adp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/adam_parameter_update.sv =====
// Top level of the Adam parameter update block: sequencer plus datapath.
// Depends on adp_pkg, adp_if, adp_ctrl and adp_datapath.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          param_index, param_value, gradient, end_of_step
//   rsp_chan  out  valid/ready          new_value, saturated
//   csr_chan  in   valid/ready          index, data
//
// One request spends most of its time in the three bit-serial divisions
// and the square root, all in turn.
// An end_of_step request adds the E1, E2 and RATE0 states, plus the divider
// again when rate decay is nonzero; writes of the learning rate or decay
// take the same path. After reset the moment memories are cleared, one
// entry a cycle; requests are held off meanwhile, register writes too.
// The response register lets a new request start while a result waits.
module adam_parameter_update #(
   parameter int NUM_PARAMS = 1024
) (
   input logic      clock,
   input logic      reset,
   adp_req_if.sink  req_chan,
   adp_rsp_if.source rsp_chan,
   adp_csr_if.sink  csr_chan
);
   import adp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   adp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   adp_datapath #(.NUM_PARAMS(NUM_PARAMS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_param_index (req_chan.param_index),
      .req_param_value (req_chan.param_value),
      .req_gradient    (req_chan.gradient),
      .req_end_of_step (req_chan.end_of_step),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_new_value   (rsp_chan.new_value),
      .rsp_saturated   (rsp_chan.saturated)
   );
endmodule

// ===== rtl/core/adp_divider.sv =====
// Restoring divider, one quotient bit per cycle; dividend is left-aligned.
// Depends on adp_pkg for operand widths.
module adp_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [adp_pkg::DIV_NUM_W-1:0]      numer,
   input  logic [adp_pkg::DIV_DEN_W-1:0]      denom,
   input  logic [adp_pkg::DIV_CNT_W-1:0]      iters,
   output logic                               done,
   output logic [adp_pkg::DIV_NUM_W-1:0]      quotient
);
   import adp_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIV_DEN_W:0]   trial, diff;
   logic                 fits;

   assign trial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = iters;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/core/adp_sqrt.sv =====
// Integer square root of a 64-bit radicand, one result bit per cycle.
// Depends on adp_pkg only by convention of the block.
module adp_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import adp_pkg::*;

   logic [63:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in, sum;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in, ge;

   assign sum = res_ff + bit_ff;
   assign ge  = x_ff >= sum;

   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         x_in    = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         x_in   = ge ? x_ff - sum : x_ff;
         res_in = ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule

// ===== rtl/core/adp_datapath.sv =====
// Datapath: registers, moment memories, multipliers, divider and sqrt units.
// Depends on adp_pkg, adp_divider and adp_sqrt; driven by adp_ctrl commands.
module adp_datapath #(
   parameter int NUM_PARAMS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  adp_pkg::dp_cmd_type               cmd,
   output adp_pkg::dp_status_type            status,
   input  logic [adp_pkg::IDX_W-1:0]         req_param_index,
   input  logic [adp_pkg::VAL_W-1:0]         req_param_value,
   input  logic [adp_pkg::VAL_W-1:0]         req_gradient,
   input  logic                              req_end_of_step,
   input  logic [adp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [adp_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [adp_pkg::VAL_W-1:0]         rsp_new_value,
   output logic                              rsp_saturated
);
   import adp_pkg::*;

   localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int MW = 27;
   localparam logic [MW-1:0]      NP_W    = MW'(NUM_PARAMS);
   localparam logic signed [50:0] RES_MAX = 51'sh7FFFFFFF;
   localparam logic signed [50:0] RES_MIN = -51'sh80000000;

   logic [31:0] mom_mem   [NUM_PARAMS];
   logic [31:0] cache_mem [NUM_PARAMS];

   logic [23:0] base_ff, decay_ff, lr_ff;
   logic [15:0] eps_ff, b1_ff, b2_ff;
   logic [31:0] count_ff, bp1_ff, bp2_ff;
   logic [AW-1:0] clr_ff;

   logic [IDX_W-1:0] idx_ff;
   logic [3:0]       modk_ff;
   logic [31:0]      p_ff, g_ff, mold_q, cold_q, mnew_ff, vnew_ff;
   logic             eos_ff;
   logic signed [65:0] acc_ff;
   logic [46:0] g2_ff;
   logic [47:0] mhat_ff, vhat_ff;
   logic [48:0] den_ff;
   logic [55:0] ratio_ff;
   logic [31:0] out_val_ff;
   logic        out_sat_ff;

   logic [AW-1:0]    addr;
   logic [MW-1:0]    mod_cand;
   logic             mod_ge;
   logic signed [48:0] p_m1;
   logic signed [49:0] p_m2;
   logic [16:0] k1, k2;
   logic [31:0] gmag, mmag;
   logic [63:0] p_g2;
   logic [47:0] p_v1;
   logic [40:0] p_vh;
   logic [39:0] p_vl;
   logic [49:0] vq;
   logic [31:0] vsat;
   logic [55:0] p_s1;
   logic [47:0] p_s2, p_e1, p_e2;
   logic [55:0] p_r;
   logic [48:0] den_sum;
   logic signed [50:0] pext, stepx, res;
   logic [31:0] root;
   logic        sqrt_done;
   logic        div_start, div_done;
   logic [DIV_NUM_W-1:0] div_numer, div_quo;
   logic [DIV_DEN_W-1:0] div_denom;
   logic [DIV_CNT_W-1:0] div_iters;

   assign addr     = AW'(idx_ff);
   assign mod_cand = NP_W << modk_ff;
   assign mod_ge   = {17'b0, idx_ff} >= mod_cand;

   assign k1   = 17'd65536 - {1'b0, b1_ff};
   assign k2   = 17'd65536 - {1'b0, b2_ff};
   assign p_m1 = $signed({1'b0, b1_ff}) * $signed(mold_q);
   assign p_m2 = $signed({1'b0, k1}) * $signed(g_ff);
   assign gmag = g_ff[31] ? ~g_ff + 32'd1 : g_ff;
   assign mmag = mnew_ff[31] ? ~mnew_ff + 32'd1 : mnew_ff;
   assign p_g2 = gmag * gmag;
   assign p_v1 = cold_q * b2_ff;
   assign p_vh = k2 * g2_ff[46:23];
   assign p_vl = k2 * g2_ff[22:0];
   assign vq   = acc_ff[65:16];
   assign vsat = (vq > 50'hFFFF_FFFF) ? 32'hFFFF_FFFF : vq[31:0];
   assign p_s1 = ratio_ff[55:24] * lr_ff;
   assign p_s2 = ratio_ff[23:0] * lr_ff;
   assign p_e1 = bp1_ff * b1_ff;
   assign p_e2 = bp2_ff * b2_ff;
   assign p_r  = decay_ff * count_ff;
   assign den_sum = {1'b0, root, 16'b0} + 49'(eps_ff);

   assign pext  = $signed({{19{p_ff[31]}}, p_ff});
   assign stepx = $signed({2'b0, acc_ff[56:8]});
   assign res   = mnew_ff[31] ? pext + stepx : pext - stepx;

   always_comb begin
      div_start = 1'b1;
      div_numer = '0;
      div_denom = '0;
      div_iters = DIV_CNT_W'(64);
      case (cmd.op)
         OP_DIV_M: begin
            div_numer = {mmag, 56'b0};
            div_denom = DIV_DEN_W'(33'h1_0000_0000 - {1'b0, bp1_ff});
         end
         OP_DIV_V: begin
            div_numer = {vnew_ff, 56'b0};
            div_denom = DIV_DEN_W'(33'h1_0000_0000 - {1'b0, bp2_ff});
         end
         OP_DIV_R: begin
            div_numer = {mhat_ff, 40'b0};
            div_denom = DIV_DEN_W'(den_ff);
            div_iters = DIV_CNT_W'(88);
         end
         OP_RATE1: begin
            div_numer = {base_ff, 64'b0};
            div_denom = acc_ff[DIV_DEN_W-1:0] + DIV_DEN_W'(65536);
            div_iters = DIV_CNT_W'(40);
         end
         default: div_start = 1'b0;
      endcase
   end

   adp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .iters    (div_iters),
      .done     (div_done),
      .quotient (div_quo)
   );

   adp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_SQRT),
      .radicand ({vhat_ff, 16'b0}),
      .done     (sqrt_done),
      .root     (root)
   );

   // moment memories: clearing sweep after reset, else one write per item
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLEAR) begin
         mom_mem[clr_ff]   <= '0;
         cache_mem[clr_ff] <= '0;
      end else if (cmd.op == OP_V4) begin
         mom_mem[addr]   <= mnew_ff;
         cache_mem[addr] <= vsat;
      end
      if (cmd.op == OP_READ) begin
         mold_q <= mom_mem[addr];
         cold_q <= cache_mem[addr];
      end
   end

   // configuration and iteration state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= RST_BASE_LR;
         decay_ff <= '0;
         eps_ff   <= RST_EPSILON;
         b1_ff    <= RST_BETA1;
         b2_ff    <= RST_BETA2;
         count_ff <= '0;
         bp1_ff   <= {RST_BETA1, 16'b0};
         bp2_ff   <= {RST_BETA2, 16'b0};
         lr_ff    <= RST_BASE_LR;
         clr_ff   <= '0;
      end else begin
         case (cmd.op)
            OP_CLEAR: clr_ff <= clr_ff + 1'b1;
            OP_CSR: begin
               unique case (csr_index)
                  CSR_BASE_LR: base_ff  <= csr_data;
                  CSR_DECAY:   decay_ff <= csr_data;
                  CSR_EPSILON: eps_ff   <= csr_data[15:0];
                  CSR_BETA1: begin
                     b1_ff <= csr_data[15:0];
                     if (count_ff == '0) bp1_ff <= {csr_data[15:0], 16'b0};
                  end
                  CSR_BETA2: begin
                     b2_ff <= csr_data[15:0];
                     if (count_ff == '0) bp2_ff <= {csr_data[15:0], 16'b0};
                  end
                  default: ;
               endcase
            end
            OP_E1: begin
               count_ff <= count_ff + 32'd1;
               bp1_ff   <= p_e1[47:16];
            end
            OP_E2:     bp2_ff <= p_e2[47:16];
            OP_RATE0:  if (decay_ff == '0) lr_ff <= base_ff;
            OP_CAP_LR: lr_ff <= div_quo[23:0];
            default: ;
         endcase
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            idx_ff  <= req_param_index;
            modk_ff <= 4'd9;
            p_ff    <= req_param_value;
            g_ff    <= req_gradient;
            eos_ff  <= req_end_of_step;
         end
         OP_MOD: begin
            if (mod_ge) idx_ff <= idx_ff - mod_cand[IDX_W-1:0];
            if (modk_ff != 4'd0) modk_ff <= modk_ff - 4'd1;
         end
         OP_M1:    acc_ff  <= 66'(p_m1);
         OP_M2:    acc_ff  <= acc_ff + 66'(p_m2);
         OP_M3:    mnew_ff <= acc_ff[47:16];
         OP_G2:    g2_ff   <= p_g2[62:16];
         OP_V1:    acc_ff  <= $signed({18'b0, p_v1});
         OP_V2:    acc_ff  <= acc_ff + $signed({2'b0, p_vh, 23'b0});
         OP_V3:    acc_ff  <= acc_ff + $signed({26'b0, p_vl});
         OP_V4:    vnew_ff <= vsat;
         OP_CAP_M: mhat_ff <= div_quo[47:0];
         OP_CAP_V: vhat_ff <= div_quo[47:0];
         // zero denominator counts as one LSB
         OP_CAP_S: den_ff  <= (den_sum == '0) ? 49'd1 : den_sum;
         OP_CAP_R: ratio_ff <= (|div_quo[87:56]) ? '1 : div_quo[55:0];
         OP_S1:    acc_ff  <= $signed({10'b0, p_s1});
         OP_S2:    acc_ff  <= acc_ff + $signed({42'b0, p_s2[47:24]});
         OP_OUT: begin
            if (res > RES_MAX) begin
               out_val_ff <= 32'h7FFF_FFFF;
               out_sat_ff <= 1'b1;
            end else if (res < RES_MIN) begin
               out_val_ff <= 32'h8000_0000;
               out_sat_ff <= 1'b1;
            end else begin
               out_val_ff <= res[31:0];
               out_sat_ff <= 1'b0;
            end
         end
         OP_RATE0: acc_ff <= $signed({10'b0, p_r});
         default: ;
      endcase
   end

   assign status.clr_last   = clr_ff == AW'(NUM_PARAMS - 1);
   assign status.mod_last   = modk_ff == 4'd0;
   assign status.div_done   = div_done;
   assign status.sqrt_done  = sqrt_done;
   assign status.eos        = eos_ff;
   assign status.decay_zero = decay_ff == '0;
   assign status.csr_rate   = (csr_index == CSR_BASE_LR) || (csr_index == CSR_DECAY);

   assign rsp_new_value = out_val_ff;
   assign rsp_saturated = out_sat_ff;
endmodule

// ===== rtl/core/adp_ctrl.sv =====
// Sequencer: walks one request through the datapath and owns the handshakes.
// Depends on adp_pkg for command and status types.
module adp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  adp_pkg::dp_status_type status,
   output adp_pkg::dp_cmd_type    cmd
);
   import adp_pkg::*;

   typedef enum logic [27:0] {
      ST_CLEAR = 28'h0000001, ST_IDLE  = 28'h0000002, ST_MOD   = 28'h0000004,
      ST_READ  = 28'h0000008, ST_M1    = 28'h0000010, ST_M2    = 28'h0000020,
      ST_M3    = 28'h0000040, ST_G2    = 28'h0000080, ST_V1    = 28'h0000100,
      ST_V2    = 28'h0000200, ST_V3    = 28'h0000400, ST_V4    = 28'h0000800,
      ST_DIVM  = 28'h0001000, ST_WAITM = 28'h0002000, ST_DIVV  = 28'h0004000,
      ST_WAITV = 28'h0008000, ST_SQS   = 28'h0010000, ST_WAITS = 28'h0020000,
      ST_DIVR  = 28'h0040000, ST_WAITR = 28'h0080000, ST_S1    = 28'h0100000,
      ST_S2    = 28'h0200000, ST_FIN   = 28'h0400000, ST_E1    = 28'h0800000,
      ST_E2    = 28'h1000000, ST_RATE0 = 28'h2000000, ST_RATE1 = 28'h4000000,
      ST_RATE2 = 28'h8000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign csr_ready = state_ff == ST_IDLE;
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NOP;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_valid) begin
               cmd.op = OP_CSR;
               if (status.csr_rate) state_in = ST_RATE0;
            end else if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.op = OP_MOD;
            if (status.mod_last) state_in = ST_READ;
         end
         ST_READ: begin cmd.op = OP_READ; state_in = ST_M1; end
         ST_M1:   begin cmd.op = OP_M1;   state_in = ST_M2; end
         ST_M2:   begin cmd.op = OP_M2;   state_in = ST_M3; end
         ST_M3:   begin cmd.op = OP_M3;   state_in = ST_G2; end
         ST_G2:   begin cmd.op = OP_G2;   state_in = ST_V1; end
         ST_V1:   begin cmd.op = OP_V1;   state_in = ST_V2; end
         ST_V2:   begin cmd.op = OP_V2;   state_in = ST_V3; end
         ST_V3:   begin cmd.op = OP_V3;   state_in = ST_V4; end
         ST_V4:   begin cmd.op = OP_V4;   state_in = ST_DIVM; end
         ST_DIVM: begin cmd.op = OP_DIV_M; state_in = ST_WAITM; end
         ST_WAITM: begin
            if (status.div_done) begin cmd.op = OP_CAP_M; state_in = ST_DIVV; end
         end
         ST_DIVV: begin cmd.op = OP_DIV_V; state_in = ST_WAITV; end
         ST_WAITV: begin
            if (status.div_done) begin cmd.op = OP_CAP_V; state_in = ST_SQS; end
         end
         ST_SQS:  begin cmd.op = OP_SQRT; state_in = ST_WAITS; end
         ST_WAITS: begin
            if (status.sqrt_done) begin cmd.op = OP_CAP_S; state_in = ST_DIVR; end
         end
         ST_DIVR: begin cmd.op = OP_DIV_R; state_in = ST_WAITR; end
         ST_WAITR: begin
            if (status.div_done) begin cmd.op = OP_CAP_R; state_in = ST_S1; end
         end
         ST_S1:   begin cmd.op = OP_S1; state_in = ST_S2; end
         ST_S2:   begin cmd.op = OP_S2; state_in = ST_FIN; end
         ST_FIN: begin
            // output register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = status.eos ? ST_E1 : ST_IDLE;
            end
         end
         ST_E1:    begin cmd.op = OP_E1; state_in = ST_E2; end
         ST_E2:    begin cmd.op = OP_E2; state_in = ST_RATE0; end
         ST_RATE0: begin
            cmd.op   = OP_RATE0;
            state_in = status.decay_zero ? ST_IDLE : ST_RATE1;
         end
         ST_RATE1: begin cmd.op = OP_RATE1; state_in = ST_RATE2; end
         ST_RATE2: begin
            if (status.div_done) begin cmd.op = OP_CAP_LR; state_in = ST_IDLE; end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== rtl/core/adp_checker.sv =====
// Port-level assertions for adam_parameter_update, bound to the top level.
// Depends on adp_pkg for widths.
module adp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [adp_pkg::VAL_W-1:0] rsp_new_value,
   input logic                      rsp_saturated
);
   import adp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_value)
                                  && $stable(rsp_saturated))
      else $error("response dropped or changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !csr_ready)
      else $error("new request or write taken while a request is in flight");

   a_one_accept: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !(req_valid && req_ready))
      else $error("request and register write accepted together");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response before its request was processed");
endmodule

bind adam_parameter_update adp_checker u_adp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .csr_valid     (csr_chan.valid),
   .csr_ready     (csr_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_new_value (rsp_chan.new_value),
   .rsp_saturated (rsp_chan.saturated)
);
